// ----- rtl/core/rv64_pkg.sv -----
// rv64_pkg: shared types, codes and decode helpers of the rv64i execute core
// no dependencies
`default_nettype none
package rv64_pkg;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_STARTED = 3'd0;
    localparam logic [2:0] KIND_RETIRED = 3'd1;
    localparam logic [2:0] KIND_LDREQ   = 3'd2;
    localparam logic [2:0] KIND_HALTED  = 3'd3;
    localparam logic [2:0] KIND_ILLEGAL = 3'd4;
    localparam logic [2:0] KIND_ORDER   = 3'd5;

    // instruction classes
    localparam logic [2:0] CLS_LOAD   = 3'd0;
    localparam logic [2:0] CLS_STORE  = 3'd1;
    localparam logic [2:0] CLS_LOGIC  = 3'd2;
    localparam logic [2:0] CLS_ARITH  = 3'd3;
    localparam logic [2:0] CLS_BRANCH = 3'd4;
    localparam logic [2:0] CLS_JUMP   = 3'd5;

    // major opcodes (bits 6:2)
    localparam logic [4:0] OPC_LOAD   = 5'd0;
    localparam logic [4:0] OPC_OPIMM  = 5'd4;
    localparam logic [4:0] OPC_AUIPC  = 5'd5;
    localparam logic [4:0] OPC_OPIMMW = 5'd6;
    localparam logic [4:0] OPC_STORE  = 5'd8;
    localparam logic [4:0] OPC_OP     = 5'd12;
    localparam logic [4:0] OPC_LUI    = 5'd13;
    localparam logic [4:0] OPC_OPW    = 5'd14;
    localparam logic [4:0] OPC_BRANCH = 5'd24;
    localparam logic [4:0] OPC_JALR   = 5'd25;
    localparam logic [4:0] OPC_JAL    = 5'd27;
    localparam logic [4:0] OPC_SYSTEM = 5'd28;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    // config register indexes and reset values
    localparam logic CFG_ENTRY_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;
    localparam logic [63:0] ENTRY_PC_RST  = 64'h1d4;
    localparam logic [63:0] STACK_TOP_RST = 64'h0e00_0000;

    // alu operations
    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR,
        ALU_SRL, ALU_SRA, ALU_OR, ALU_AND, ALU_PASSB, ALU_PCB
    } t_alu_op;

    // what the back end does with a queued item
    typedef enum logic [2:0] {
        ACT_START, ACT_ALU, ACT_LOAD, ACT_STORE, ACT_BRANCH, ACT_JAL, ACT_JALR,
        ACT_FIXED
    } t_action;

    // classified item travelling from front to back
    typedef struct packed {
        t_action     act;
        logic [2:0]  fixed_kind;
        logic [1:0]  mode;
        t_alu_op     alu_op;
        logic        word_op;
        logic        use_imm;
        logic [2:0]  f3;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  rd;
        logic [2:0]  cls;
        logic [31:0] imm;
        logic [63:0] load_data;
    } t_uop;

endpackage
`default_nettype wire

// ----- rtl/core/rv64_if.sv -----
// rv64_in_if, rv64_out_if and rv64_cfg_if: valid/ready channels of the core
// depends on nothing; payload types are parameter-free plain vectors
`default_nettype none
interface rv64_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] instr_word;
    logic [63:0] load_data;
    modport source (output valid, mode, instr_word, load_data, input ready);
    modport sink (input valid, mode, instr_word, load_data, output ready);
endinterface

interface rv64_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] instr_pc;
    logic [2:0]  instr_class;
    logic [63:0] mem_address;
    logic [1:0]  access_size;
    logic [63:0] store_data;
    logic [63:0] next_pc;
    logic [4:0]  dest_reg;
    logic [63:0] dest_value;
    logic        dest_written;
    logic signed [31:0] immediate;
    modport source (output valid, kind, instr_pc, instr_class, mem_address, access_size,
                    store_data, next_pc, dest_reg, dest_value, dest_written, immediate,
                    input ready);
    modport sink (input valid, kind, instr_pc, instr_class, mem_address, access_size,
                  store_data, next_pc, dest_reg, dest_value, dest_written, immediate,
                  output ready);
endinterface

interface rv64_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rv64_front.sv -----
// rv64_front: decodes and classifies input items into queue entries
// depends on rv64_pkg
`default_nettype none
module rv64_front (
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_instr_word,
    input  wire logic [63:0] i_load_data,
    output rv64_pkg::t_uop   o_uop
);
    import rv64_pkg::*;

    logic [31:0] w;
    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi, imms, immb, immu, immj;
    logic        ill;

    assign w    = i_instr_word;
    assign opc  = w[6:2];
    assign f3   = w[14:12];
    assign f7   = w[31:25];
    assign immi = {{20{w[31]}}, w[31:20]};
    assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immu = {w[31:12], 12'h000};
    assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    // instruction decoder
    always_comb begin
        o_uop           = '0;
        o_uop.mode      = i_mode;
        o_uop.f3        = f3;
        o_uop.rs1       = w[19:15];
        o_uop.rs2       = w[24:20];
        o_uop.rd        = w[11:7];
        o_uop.load_data = i_load_data;
        o_uop.act       = ACT_ALU;
        o_uop.alu_op    = ALU_ADD;
        o_uop.cls       = CLS_LOGIC;
        ill             = 1'b0;
        unique case (opc)
            OPC_LOAD: begin
                o_uop.act = ACT_LOAD; o_uop.imm = immi; o_uop.cls = CLS_LOAD;
                ill = (f3 == 3'd7);
            end
            OPC_OPIMM, OPC_OPIMMW: begin
                o_uop.imm = immi; o_uop.use_imm = 1'b1;
                o_uop.word_op = (opc == OPC_OPIMMW);
                case (f3)
                    3'd0: begin o_uop.alu_op = ALU_ADD; o_uop.cls = CLS_ARITH; end
                    3'd1: begin
                        o_uop.alu_op = ALU_SLL;
                        ill = o_uop.word_op ? (f7 != 7'd0) : (w[31:26] != 6'd0);
                    end
                    3'd2: begin o_uop.alu_op = ALU_SLT; ill = o_uop.word_op; end
                    3'd3: begin o_uop.alu_op = ALU_SLTU; ill = o_uop.word_op; end
                    3'd4: begin o_uop.alu_op = ALU_XOR; ill = o_uop.word_op; end
                    3'd5: begin
                        o_uop.alu_op = w[30] ? ALU_SRA : ALU_SRL;
                        if (o_uop.word_op) ill = (f7 != 7'h00) && (f7 != 7'h20);
                        else ill = (w[31:26] != 6'h00) && (w[31:26] != 6'h10);
                    end
                    3'd6: begin o_uop.alu_op = ALU_OR; ill = o_uop.word_op; end
                    default: begin o_uop.alu_op = ALU_AND; ill = o_uop.word_op; end
                endcase
            end
            OPC_OP, OPC_OPW: begin
                o_uop.word_op = (opc == OPC_OPW);
                ill = (f7 != 7'h00) && (f7 != 7'h20);
                if (f7 == 7'h20 && f3 != 3'd0 && f3 != 3'd5) ill = 1'b1;
                if (o_uop.word_op && f3 != 3'd0 && f3 != 3'd1 && f3 != 3'd5) ill = 1'b1;
                case (f3)
                    3'd0: begin
                        o_uop.alu_op = w[30] ? ALU_SUB : ALU_ADD; o_uop.cls = CLS_ARITH;
                    end
                    3'd1: o_uop.alu_op = ALU_SLL;
                    3'd2: o_uop.alu_op = ALU_SLT;
                    3'd3: o_uop.alu_op = ALU_SLTU;
                    3'd4: o_uop.alu_op = ALU_XOR;
                    3'd5: o_uop.alu_op = w[30] ? ALU_SRA : ALU_SRL;
                    3'd6: o_uop.alu_op = ALU_OR;
                    default: o_uop.alu_op = ALU_AND;
                endcase
            end
            OPC_AUIPC: begin
                o_uop.alu_op = ALU_PCB; o_uop.use_imm = 1'b1; o_uop.imm = immu;
                o_uop.cls = CLS_ARITH;
            end
            OPC_LUI: begin
                o_uop.alu_op = ALU_PASSB; o_uop.use_imm = 1'b1; o_uop.imm = immu;
                o_uop.cls = CLS_ARITH;
            end
            OPC_STORE: begin
                o_uop.act = ACT_STORE; o_uop.imm = imms; o_uop.cls = CLS_STORE;
                ill = f3[2];
            end
            OPC_BRANCH: begin
                o_uop.act = ACT_BRANCH; o_uop.imm = immb; o_uop.cls = CLS_BRANCH;
                ill = (f3 == 3'd2) || (f3 == 3'd3);
            end
            OPC_JALR: begin
                o_uop.act = ACT_JALR; o_uop.imm = immi; o_uop.cls = CLS_JUMP;
                ill = (f3 != 3'd0);
            end
            OPC_JAL: begin
                o_uop.act = ACT_JAL; o_uop.imm = immj; o_uop.cls = CLS_JUMP;
            end
            OPC_SYSTEM: begin
                o_uop.act = ACT_FIXED; o_uop.fixed_kind = KIND_HALTED; o_uop.imm = immi;
                ill = (w != WORD_ECALL) && (w != WORD_EBREAK);
            end
            default: ill = 1'b1;
        endcase
        if (w[1:0] != 2'b11) ill = 1'b1;
        if (ill) begin
            o_uop.act = ACT_FIXED; o_uop.fixed_kind = KIND_ILLEGAL;
        end
        if (i_mode == MODE_START) o_uop.act = ACT_START;
    end
endmodule
`default_nettype wire

// ----- rtl/core/rv64_queue.sv -----
// rv64_queue: two-entry fifo of classified items between front and back
// depends on rv64_pkg
`default_nettype none
module rv64_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  rv64_pkg::t_uop      i_uop,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rv64_pkg::t_uop      o_uop
);
    import rv64_pkg::*;

    t_uop       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_uop   = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_uop;
    end
endmodule
`default_nettype wire

// ----- rtl/core/rv64_back.sv -----
// rv64_back: architectural state, alu and result register
// depends on rv64_pkg
`default_nettype none
module rv64_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  rv64_pkg::t_uop      i_uop,
    output logic                o_pop,
    input  wire logic [63:0]    i_entry_pc,
    input  wire logic [63:0]    i_stack_top,
    rv64_out_if.source          out
);
    import rv64_pkg::*;

    logic [63:0] r_rf [32];
    logic [63:0] r_pc, r_ppc, r_paddr;
    logic        r_await, r_halted;
    logic [4:0]  r_pdest;
    logic [2:0]  r_pw;
    logic [31:0] r_pimm;

    // output register
    logic        r_ov;
    logic [2:0]  r_kind, r_cls;
    logic [63:0] r_ipc, r_addr, r_sdata, r_npc, r_dval;
    logic [1:0]  r_size;
    logic [4:0]  r_drd;
    logic        r_dwr;
    logic [31:0] r_imm;

    logic [63:0] a, b, opb, imm64, pc4, alu, ldv, sum;
    logic [5:0]  sh;
    logic        take;
    logic        can;

    assign can   = !r_ov || out.ready;
    assign o_pop = i_valid && can;

    assign a     = (i_uop.rs1 == 5'd0) ? 64'd0 : r_rf[i_uop.rs1];
    assign b     = (i_uop.rs2 == 5'd0) ? 64'd0 : r_rf[i_uop.rs2];
    assign imm64 = {{32{i_uop.imm[31]}}, i_uop.imm};
    assign opb   = i_uop.use_imm ? imm64 : b;
    assign pc4   = r_pc + 64'd4;
    assign sum   = a + imm64;
    assign sh    = i_uop.word_op ? {1'b0, opb[4:0]} : opb[5:0];

    // alu
    always_comb begin
        logic [63:0] sa;
        sa = i_uop.word_op ? (i_uop.alu_op == ALU_SRA ? {{32{a[31]}}, a[31:0]}
                                                      : {32'd0, a[31:0]}) : a;
        case (i_uop.alu_op)
            ALU_ADD:   alu = a + opb;
            ALU_SUB:   alu = a - opb;
            ALU_SLL:   alu = a << sh;
            ALU_SLT:   alu = {63'd0, $signed(a) < $signed(opb)};
            ALU_SLTU:  alu = {63'd0, a < opb};
            ALU_XOR:   alu = a ^ opb;
            ALU_SRL:   alu = sa >> sh;
            ALU_SRA:   alu = $unsigned($signed(sa) >>> sh);
            ALU_OR:    alu = a | opb;
            ALU_AND:   alu = a & opb;
            ALU_PASSB: alu = opb;
            default:   alu = r_pc + opb;
        endcase
        if (i_uop.word_op) alu = {{32{alu[31]}}, alu[31:0]};
    end

    // branch compare
    always_comb begin
        case (i_uop.f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            default: take = a >= b;
        endcase
    end

    // load data extension
    always_comb begin
        logic [63:0] d;
        d = i_uop.load_data;
        case (r_pw)
            3'd0: ldv = {{56{d[7]}}, d[7:0]};
            3'd1: ldv = {{48{d[15]}}, d[15:0]};
            3'd2: ldv = {{32{d[31]}}, d[31:0]};
            3'd4: ldv = {56'd0, d[7:0]};
            3'd5: ldv = {48'd0, d[15:0]};
            3'd6: ldv = {32'd0, d[31:0]};
            default: ldv = d;
        endcase
    end

    // execute and update state
    always_ff @(posedge i_clk) begin
        logic [2:0]  k, c;
        logic [63:0] ipc, ad, sd, np, dv, wv;
        logic [1:0]  sz;
        logic [4:0]  rd;
        logic        wr;
        logic [31:0] im;
        logic        ok;
        k = KIND_ORDER; c = CLS_LOAD; ipc = r_pc; ad = '0; sd = '0; np = r_pc;
        dv = '0; wv = '0; sz = '0; rd = '0; wr = 1'b0; im = '0; ok = 1'b0;
        if (!i_rst_n) begin
            r_ov <= 1'b0; r_pc <= ENTRY_PC_RST; r_await <= 1'b0; r_halted <= 1'b0;
            r_pdest <= '0; r_pw <= '0; r_paddr <= '0; r_ppc <= '0; r_pimm <= '0;
            for (int i = 0; i < 32; i++) r_rf[i] <= (i == 2) ? STACK_TOP_RST : 64'd0;
        end else begin
            r_ov <= o_pop || (r_ov && !out.ready);
            if (o_pop) begin
                if (i_uop.act == ACT_START) begin
                    for (int i = 0; i < 32; i++) r_rf[i] <= (i == 2) ? i_stack_top : 64'd0;
                    r_pc <= i_entry_pc; r_await <= 1'b0; r_halted <= 1'b0;
                    r_pdest <= '0; r_pw <= '0; r_paddr <= '0; r_ppc <= '0; r_pimm <= '0;
                    k = KIND_STARTED; ipc = i_entry_pc; np = i_entry_pc;
                end else if (i_uop.mode == MODE_LOAD && r_await) begin
                    r_await <= 1'b0;
                    k = KIND_RETIRED; ipc = r_ppc; ad = r_paddr; sz = r_pw[1:0];
                    np = r_ppc + 64'd4; im = r_pimm; rd = r_pdest; wv = ldv; ok = 1'b1;
                end else if (i_uop.mode == MODE_EXEC && !r_halted && !r_await) begin
                    im = i_uop.imm; c = i_uop.cls; np = pc4;
                    case (i_uop.act)
                        ACT_LOAD: begin
                            k = KIND_LDREQ; ad = sum; sz = i_uop.f3[1:0]; rd = i_uop.rd;
                            r_await <= 1'b1; r_pdest <= i_uop.rd; r_pw <= i_uop.f3;
                            r_paddr <= sum; r_ppc <= r_pc; r_pimm <= i_uop.imm;
                            r_pc <= pc4;
                        end
                        ACT_STORE: begin
                            k = KIND_RETIRED; ad = sum; sz = i_uop.f3[1:0]; sd = b;
                            r_pc <= pc4;
                        end
                        ACT_BRANCH: begin
                            k = KIND_RETIRED;
                            if (take) np = r_pc + imm64;
                            r_pc <= np;
                        end
                        ACT_JAL: begin
                            k = KIND_RETIRED; np = r_pc + imm64; rd = i_uop.rd; wv = pc4;
                            ok = 1'b1; r_pc <= np;
                        end
                        ACT_JALR: begin
                            k = KIND_RETIRED; np = {sum[63:1], 1'b0}; rd = i_uop.rd;
                            wv = pc4; ok = 1'b1; r_pc <= np;
                        end
                        ACT_ALU: begin
                            k = KIND_RETIRED; rd = i_uop.rd; wv = alu; ok = 1'b1;
                            r_pc <= pc4;
                        end
                        default: begin
                            // halt and illegal report the class code CLS_LOAD
                            k = i_uop.fixed_kind; np = r_pc; c = CLS_LOAD;
                            if (k == KIND_HALTED) r_halted <= 1'b1;
                            else im = '0;
                        end
                    endcase
                end
                if (ok && rd != 5'd0) begin
                    r_rf[rd] <= wv; dv = wv; wr = 1'b1;
                end
                r_kind <= k; r_cls <= c; r_ipc <= ipc; r_addr <= ad; r_sdata <= sd;
                r_npc <= np; r_size <= sz; r_drd <= rd; r_dval <= dv; r_dwr <= wr;
                r_imm <= im;
            end
        end
    end

    assign out.valid        = r_ov;
    assign out.kind         = r_kind;
    assign out.instr_pc     = r_ipc;
    assign out.instr_class  = r_cls;
    assign out.mem_address  = r_addr;
    assign out.access_size  = r_size;
    assign out.store_data   = r_sdata;
    assign out.next_pc      = r_npc;
    assign out.dest_reg     = r_drd;
    assign out.dest_value   = r_dval;
    assign out.dest_written = r_dwr;
    assign out.immediate    = r_imm;
endmodule
`default_nettype wire

// ----- rtl/core/rv64i_integer_execute_core.sv -----
// rv64i_integer_execute_core: top level of the rv64i execute core
// depends on rv64_pkg, rv64_if, rv64_front, rv64_queue, rv64_back
//
//  channel   direction  payload
//  in        sink       mode, instr_word, load_data
//  out       source     kind, instr_pc, instr_class, mem_address, ... immediate
//  cfg       sink       index, data (entry_pc, stack_top)
//
// the front decodes an item in the cycle it is accepted and queues it (two entries);
// the back executes one item a cycle from the queue into the output register while the
// output is not stalled, so a steady stream runs at one item per cycle and each item is
// registered in the queue and then in the output register. reset is synchronous; a
// stalled output holds the back, and the queue then fills and drops in.ready.
`default_nettype none
module rv64i_integer_execute_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rv64_in_if.sink   in,
    rv64_cfg_if.sink  cfg,
    rv64_out_if.source out
);
    import rv64_pkg::*;

    t_uop        fr_uop, q_uop;
    logic        q_full, q_valid, pop, push;
    logic [63:0] r_entry_pc, r_stack_top;

    assign in.ready  = !q_full;
    assign push      = in.valid && !q_full;
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_pc <= ENTRY_PC_RST; r_stack_top <= STACK_TOP_RST;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_ENTRY_PC) r_entry_pc <= cfg.data;
            else r_stack_top <= cfg.data;
        end
    end

    rv64_front u_front (
        .i_mode(in.mode), .i_instr_word(in.instr_word), .i_load_data(in.load_data),
        .o_uop(fr_uop)
    );

    rv64_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_uop(fr_uop),
        .o_full(q_full), .i_pop(pop), .o_valid(q_valid), .o_uop(q_uop)
    );

    rv64_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_uop(q_uop), .o_pop(pop),
        .i_entry_pc(r_entry_pc), .i_stack_top(r_stack_top), .out(out)
    );
endmodule
`default_nettype wire
